>>> rtl/reflow_profile_sequencer_core_defines.svh
// Assertion macros used by the reflow profile sequencer core RTL.
`ifndef REFLOW_PROFILE_SEQUENCER_CORE_DEFINES_SVH
`define REFLOW_PROFILE_SEQUENCER_CORE_DEFINES_SVH

// Checked on every clock edge outside reset
`define RPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included
`define RPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/rps_pkg.sv
// Types, codes and constants of the reflow profile sequencer.
package rps_pkg;

  localparam int TEMP_W  = 12;
  localparam int SOAK_W  = 8;
  localparam int SEQ_W   = 16;
  localparam int STAGE_W = 3;
  localparam int MODE_W  = 2;
  localparam int BEEP_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 48;

  // Stage codes
  localparam logic [STAGE_W-1:0] STAGE_RAMP_SOAK   = 3'd0;
  localparam logic [STAGE_W-1:0] STAGE_SOAKING     = 3'd1;
  localparam logic [STAGE_W-1:0] STAGE_RAMP_REFLOW = 3'd2;
  localparam logic [STAGE_W-1:0] STAGE_COOLING     = 3'd3;
  localparam logic [STAGE_W-1:0] STAGE_IDLE        = 3'd4;

  // Request kinds
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_START = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STOP  = 2'd2;

  // Beep patterns
  localparam logic [BEEP_W-1:0] BEEP_NONE       = 2'd0;
  localparam logic [BEEP_W-1:0] BEEP_SOAK_START = 2'd1;
  localparam logic [BEEP_W-1:0] BEEP_SOAK_END   = 2'd2;
  localparam logic [BEEP_W-1:0] BEEP_DONE       = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOAK_TEMP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFLOW_TEMP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOAK_PERIOD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COOL_TEMP   = 2'd3;

  // Register reset values
  localparam logic [TEMP_W-1:0] SOAK_TEMP_RST   = 12'd440;
  localparam logic [TEMP_W-1:0] REFLOW_TEMP_RST = 12'd660;
  localparam logic [SOAK_W-1:0] SOAK_PERIOD_RST = 8'd70;
  localparam logic [TEMP_W-1:0] COOL_TEMP_RST   = 12'd200;

  localparam logic [SOAK_W-1:0] SOAK_CNT_MAX = 8'hFF;
  localparam logic [3:0]        BATCH_LAST   = 4'd9;

  typedef struct packed {
    logic [TEMP_W-1:0] soak_temp;
    logic [TEMP_W-1:0] reflow_temp;
    logic [SOAK_W-1:0] soak_period;
    logic [TEMP_W-1:0] cool_done_temp;
  } cfg_t;

  typedef struct packed {
    logic [STAGE_W-1:0] stage;
    logic [SOAK_W-1:0]  soak_count;
    logic [SEQ_W-1:0]   seq_count;
    logic [3:0]         batch_pos;   // seq_count mod 10, restarts on wrap
    logic [TEMP_W-1:0]  target;
    logic               gain_set;
  } state_t;

  typedef struct packed {
    logic [STAGE_W-1:0] stage_now;
    logic [TEMP_W-1:0]  target_temp;
    logic               ctrl_select;
    logic               clear_pid;
    logic               run_pid;
    logic [BEEP_W-1:0]  beep_code;
    logic               heater_off;
    logic               record_valid;
    logic [SEQ_W-1:0]   sample_seq;
    logic               post_batch;
    logic               session_start;
    logic               profile_done;
  } result_t;

endpackage

>>> rtl/rps_step.sv
// Next-state and result logic for one sequencer request.
module rps_step (
  input  logic [rps_pkg::MODE_W-1:0] mode,
  input  logic [rps_pkg::TEMP_W-1:0] temp_now,
  input  rps_pkg::cfg_t              cfg,
  input  rps_pkg::state_t            state,
  output rps_pkg::state_t            state_next,
  output rps_pkg::result_t           res
);
  import rps_pkg::*;

  logic              record;
  logic [SOAK_W-1:0] soak_inc;
  logic [SEQ_W-1:0]  seq_inc;
  logic [3:0]        pos_inc;

  // Saturating soak second count
  assign soak_inc = (state.soak_count == SOAK_CNT_MAX) ? state.soak_count
                                                       : state.soak_count + 1'b1;
  assign seq_inc = state.seq_count + 1'b1;
  // Position inside the batch of ten; restarts when the sequence wraps
  assign pos_inc = (seq_inc == '0 || state.batch_pos == BATCH_LAST) ? 4'd0
                                                                    : state.batch_pos + 1'b1;

  always_comb begin
    state_next = state;
    res        = '0;
    record     = 1'b0;
    case (mode)
      MODE_START: begin
        res.session_start     = 1'b1;
        res.clear_pid         = 1'b1;
        state_next.gain_set   = 1'b0;
        state_next.seq_count  = '0;
        state_next.batch_pos  = '0;
        state_next.soak_count = '0;
        state_next.stage      = STAGE_RAMP_SOAK;
      end
      MODE_STOP: begin
        state_next.stage = STAGE_COOLING;
        res.heater_off   = 1'b1;
      end
      MODE_TICK: begin
        case (state.stage)
          STAGE_RAMP_SOAK: begin
            state_next.target = cfg.soak_temp;
            if (temp_now >= cfg.soak_temp) begin
              res.beep_code    = BEEP_SOAK_START;
              state_next.stage = STAGE_SOAKING;
            end
            res.run_pid = 1'b1;
            record      = 1'b1;
          end
          STAGE_SOAKING: begin
            state_next.soak_count = soak_inc;
            if (soak_inc >= cfg.soak_period) begin
              res.beep_code       = BEEP_SOAK_END;
              res.clear_pid       = 1'b1;
              state_next.gain_set = 1'b1;
              state_next.stage    = STAGE_RAMP_REFLOW;
            end
            res.run_pid = 1'b1;
            record      = 1'b1;
          end
          STAGE_RAMP_REFLOW: begin
            state_next.target = cfg.reflow_temp;
            if (temp_now >= cfg.reflow_temp) begin
              res.beep_code    = BEEP_DONE;
              res.heater_off   = 1'b1;
              state_next.stage = STAGE_COOLING;
            end else begin
              res.run_pid = 1'b1;
              record      = 1'b1;
            end
          end
          STAGE_COOLING: begin
            if (temp_now <= cfg.cool_done_temp) begin
              res.profile_done = 1'b1;
              state_next.stage = STAGE_IDLE;
            end else begin
              record = 1'b1;
            end
          end
          default: begin
          end
        endcase
        // Sample recording and batch post
        if (record) begin
          res.record_valid     = 1'b1;
          res.sample_seq       = state.seq_count;
          state_next.seq_count = seq_inc;
          state_next.batch_pos = pos_inc;
          res.post_batch       = (pos_inc == 4'd0) && (seq_inc != '0);
        end
      end
      default: begin
      end
    endcase
    res.stage_now   = state_next.stage;
    res.target_temp = state_next.target;
    res.ctrl_select = state_next.gain_set;
  end

endmodule

>>> rtl/reflow_profile_sequencer_core.sv
// Top level of the reflow oven profile sequencer.
// Each request (tick, start or stop) yields one result. Requests are taken one per
// cycle while results are taken; a request is held in an input register and its
// result is loaded into the output register once that register is free. The
// sustained rate is set by the single pass through the stage update logic. The input
// stalls only while both registers are full and the result is not taken. Thresholds
// must be written through the cfg port only while no request is in flight; the block
// itself does not enforce this.
`include "reflow_profile_sequencer_core_defines.svh"

module reflow_profile_sequencer_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [rps_pkg::IN_DATA_W-1:0]       s_tdata,   // temp_now[11:0], zeros
  input  logic [rps_pkg::MODE_W-1:0]          s_tuser,   // mode[1:0]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // stage_now[2:0], target_temp[14:3], ctrl_select[15], clear_pid[16], run_pid[17],
  // beep_code[19:18], heater_off[20], record_valid[21], sample_seq[37:22],
  // post_batch[38], session_start[39], profile_done[40], zeros[47:41]
  output logic [rps_pkg::OUT_DATA_W-1:0]      m_tdata,
  input  logic                                cfg_we,
  input  logic [rps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rps_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import rps_pkg::*;

  cfg_t              cfg;
  state_t            state;
  state_t            state_next;
  result_t           res_next;
  result_t           res;
  logic              in_valid;
  logic [MODE_W-1:0] in_mode;
  logic [TEMP_W-1:0] in_temp;
  logic              out_free;
  logic              advance;
  logic              s_fire;

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;
  assign s_fire   = s_tvalid && s_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.soak_temp      <= SOAK_TEMP_RST;
      cfg.reflow_temp    <= REFLOW_TEMP_RST;
      cfg.soak_period    <= SOAK_PERIOD_RST;
      cfg.cool_done_temp <= COOL_TEMP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SOAK_TEMP:   cfg.soak_temp      <= cfg_data[TEMP_W-1:0];
        CFG_REFLOW_TEMP: cfg.reflow_temp    <= cfg_data[TEMP_W-1:0];
        CFG_SOAK_PERIOD: cfg.soak_period    <= cfg_data[SOAK_W-1:0];
        CFG_COOL_TEMP:   cfg.cool_done_temp <= cfg_data[TEMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_fire) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      in_mode <= s_tuser;
      in_temp <= s_tdata[TEMP_W-1:0];
    end
  end

  rps_step u_step (
    .mode       (in_mode),
    .temp_now   (in_temp),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next),
    .res        (res_next)
  );

  // Profile state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.stage      <= STAGE_IDLE;
      state.soak_count <= '0;
      state.seq_count  <= '0;
      state.batch_pos  <= '0;
      state.target     <= '0;
      state.gain_set   <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tdata = {7'd0, res.profile_done, res.session_start, res.post_batch,
                    res.sample_seq, res.record_valid, res.heater_off, res.beep_code,
                    res.run_pid, res.clear_pid, res.ctrl_select, res.target_temp,
                    res.stage_now};

  // Checks
  `RPS_ASSERT(a_hoff_no_run, m_tvalid |-> !(res.heater_off && res.run_pid), "PID run with heater off")
  `RPS_ASSERT(a_post_rec, m_tvalid && res.post_batch |-> res.record_valid, "batch post without sample")
  `RPS_ASSERT(a_done_idle, m_tvalid && res.profile_done |-> res.stage_now == STAGE_IDLE, "done not idle")
  `RPS_ASSERT_ALWAYS(a_rst_empty, $past(rst) && !rst |-> !m_tvalid && !in_valid, "not empty after reset")

endmodule

>>> test/reflow_profile_sequencer_checker.sv
// Result checker for the reflow profile sequencer: predicts each result and compares it.
module reflow_profile_sequencer_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [rps_pkg::IN_DATA_W-1:0]  s_tdata,   // temp_now[11:0], zeros
  input  logic [rps_pkg::MODE_W-1:0]     s_tuser,   // mode[1:0]
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [rps_pkg::OUT_DATA_W-1:0] m_tdata,   // stage_now up to profile_done, see core
  input  logic                           cfg_we,
  input  logic [rps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rps_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                    pending,
  output int unsigned                    mismatches
);
  timeunit 1ns;
  timeprecision 1ps;
  import rps_pkg::*;

  // Threshold copies
  logic [TEMP_W-1:0]  soak_temp_q;
  logic [TEMP_W-1:0]  reflow_temp_q;
  logic [SOAK_W-1:0]  soak_period_q;
  logic [TEMP_W-1:0]  cool_temp_q;

  // Profile state
  logic [STAGE_W-1:0] stage_q;
  logic [SOAK_W-1:0]  soak_secs_q;
  logic [SEQ_W-1:0]   sample_cnt_q;
  logic [TEMP_W-1:0]  setpoint_q;
  logic               reflow_gains_q;

  // Results still owed by the block, oldest first
  result_t owed_results[$];

  initial mismatches = 0;

  // Advance the profile by one request and return the result it must produce
  function automatic result_t advance_profile(logic [MODE_W-1:0] mode,
                                              logic [TEMP_W-1:0] temp);
    result_t r;
    logic    take_sample;
    r = '0;
    take_sample = 1'b0;
    case (mode)
      MODE_START: begin
        r.session_start = 1'b1;
        r.clear_pid     = 1'b1;
        reflow_gains_q  = 1'b0;
        sample_cnt_q    = '0;
        soak_secs_q     = '0;
        stage_q         = STAGE_RAMP_SOAK;
      end
      MODE_STOP: begin
        stage_q      = STAGE_COOLING;
        r.heater_off = 1'b1;
      end
      MODE_TICK: begin
        case (stage_q)
          STAGE_RAMP_SOAK: begin
            setpoint_q = soak_temp_q;
            if (temp >= soak_temp_q) begin
              r.beep_code = BEEP_SOAK_START;
              stage_q     = STAGE_SOAKING;
            end
            r.run_pid   = 1'b1;
            take_sample = 1'b1;
          end
          STAGE_SOAKING: begin
            // soak seconds saturate
            if (soak_secs_q != SOAK_CNT_MAX) soak_secs_q = soak_secs_q + 1'b1;
            if (soak_secs_q >= soak_period_q) begin
              r.beep_code    = BEEP_SOAK_END;
              r.clear_pid    = 1'b1;
              reflow_gains_q = 1'b1;
              stage_q        = STAGE_RAMP_REFLOW;
            end
            r.run_pid   = 1'b1;
            take_sample = 1'b1;
          end
          STAGE_RAMP_REFLOW: begin
            setpoint_q = reflow_temp_q;
            if (temp >= reflow_temp_q) begin
              r.beep_code  = BEEP_DONE;
              r.heater_off = 1'b1;
              stage_q      = STAGE_COOLING;
            end else begin
              r.run_pid   = 1'b1;
              take_sample = 1'b1;
            end
          end
          STAGE_COOLING: begin
            if (temp <= cool_temp_q) begin
              r.profile_done = 1'b1;
              stage_q        = STAGE_IDLE;
            end else begin
              take_sample = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;  // unused kind: only the held state shows
    endcase
    // Sample numbering wraps at 16 bits; a batch is every tenth nonzero count
    if (take_sample) begin
      r.record_valid = 1'b1;
      r.sample_seq   = sample_cnt_q;
      sample_cnt_q   = sample_cnt_q + 1'b1;
      r.post_batch   = (sample_cnt_q != '0) && (sample_cnt_q % 10 == 0);
    end
    r.stage_now   = stage_q;
    r.target_temp = setpoint_q;
    r.ctrl_select = reflow_gains_q;
    return r;
  endfunction

  function automatic result_t unpack_result(logic [OUT_DATA_W-1:0] d);
    result_t r;
    r.stage_now     = d[2:0];
    r.target_temp   = d[14:3];
    r.ctrl_select   = d[15];
    r.clear_pid     = d[16];
    r.run_pid       = d[17];
    r.beep_code     = d[19:18];
    r.heater_off    = d[20];
    r.record_valid  = d[21];
    r.sample_seq    = d[37:22];
    r.post_batch    = d[38];
    r.session_start = d[39];
    r.profile_done  = d[40];
    return r;
  endfunction

  function automatic void check_field(string name, logic [SEQ_W-1:0] want,
                                      logic [SEQ_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void compare_result(result_t want, result_t got);
    check_field("stage_now", SEQ_W'(want.stage_now), SEQ_W'(got.stage_now));
    check_field("target_temp", SEQ_W'(want.target_temp), SEQ_W'(got.target_temp));
    check_field("ctrl_select", SEQ_W'(want.ctrl_select), SEQ_W'(got.ctrl_select));
    check_field("clear_pid", SEQ_W'(want.clear_pid), SEQ_W'(got.clear_pid));
    check_field("run_pid", SEQ_W'(want.run_pid), SEQ_W'(got.run_pid));
    check_field("beep_code", SEQ_W'(want.beep_code), SEQ_W'(got.beep_code));
    check_field("heater_off", SEQ_W'(want.heater_off), SEQ_W'(got.heater_off));
    check_field("record_valid", SEQ_W'(want.record_valid), SEQ_W'(got.record_valid));
    check_field("sample_seq", want.sample_seq, got.sample_seq);
    check_field("post_batch", SEQ_W'(want.post_batch), SEQ_W'(got.post_batch));
    check_field("session_start", SEQ_W'(want.session_start), SEQ_W'(got.session_start));
    check_field("profile_done", SEQ_W'(want.profile_done), SEQ_W'(got.profile_done));
  endfunction

  // Watch both channels and the register port
  always @(posedge clk) begin
    if (rst) begin
      soak_temp_q    = SOAK_TEMP_RST;
      reflow_temp_q  = REFLOW_TEMP_RST;
      soak_period_q  = SOAK_PERIOD_RST;
      cool_temp_q    = COOL_TEMP_RST;
      stage_q        = STAGE_IDLE;
      soak_secs_q    = '0;
      sample_cnt_q   = '0;
      setpoint_q     = '0;
      reflow_gains_q = 1'b0;
      owed_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (owed_results.size() == 0) begin
          $error("result with no request outstanding: %h", m_tdata);
          mismatches++;
        end else begin
          compare_result(owed_results.pop_front(), unpack_result(m_tdata));
        end
      end
      if (s_tvalid && s_tready)
        owed_results.push_back(advance_profile(s_tuser, s_tdata[TEMP_W-1:0]));
      if (cfg_we) begin
        case (cfg_index)
          CFG_SOAK_TEMP:   soak_temp_q   = cfg_data[TEMP_W-1:0];
          CFG_REFLOW_TEMP: reflow_temp_q = cfg_data[TEMP_W-1:0];
          CFG_SOAK_PERIOD: soak_period_q = cfg_data[SOAK_W-1:0];
          CFG_COOL_TEMP:   cool_temp_q   = cfg_data[TEMP_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= owed_results.size();
  end

endmodule

>>> test/reflow_profile_sequencer_core_test.sv
// Top of the reflow profile sequencer testbench: clock, reset, stimulus and verdict.
module reflow_profile_sequencer_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rps_pkg::*;

  localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 60000;
  localparam int unsigned HOLD_CYCLES = 250;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // temp_now[11:0], zeros
  logic [MODE_W-1:0]     s_tuser = '0;   // mode[1:0]
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // stage_now[2:0] ... profile_done[40], zeros
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned cycle_count = 0;
  int unsigned requests_sent = 0;
  int unsigned send_idle_pct = 7;
  int unsigned recv_idle_pct = 69;
  int unsigned hold_trigger = 0;

  // Thresholds as last written, used to shape profiles
  logic [TEMP_W-1:0] soak_temp_now   = SOAK_TEMP_RST;
  logic [TEMP_W-1:0] reflow_temp_now = REFLOW_TEMP_RST;
  logic [SOAK_W-1:0] soak_period_now = SOAK_PERIOD_RST;
  logic [TEMP_W-1:0] cool_temp_now   = COOL_TEMP_RST;

  reflow_profile_sequencer_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  reflow_profile_sequencer_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .mismatches (mismatches)
  );

  always #4 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL reflow_profile_sequencer_core");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off when asked
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_trigger != hold_seen) begin
        hold_seen = hold_trigger;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one request and wait until the block takes it
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [TEMP_W-1:0] temp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= IN_DATA_W'(temp);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    requests_sent++;
  endtask

  // Tick, sometimes preceded by a stray request of any kind
  task automatic profile_tick(input logic [TEMP_W-1:0] temp);
    if ($urandom_range(99) < 6)
      send_request(MODE_W'($urandom_range(3)), TEMP_W'($urandom()));
    send_request(MODE_TICK, temp);
  endtask

  // Wait until every result has come back and the pipeline is quiet
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Bring the profile to idle, drain, then rewrite all four thresholds
  task automatic load_thresholds(input logic [TEMP_W-1:0] soak_t,
                                 input logic [TEMP_W-1:0] reflow_t,
                                 input logic [SOAK_W-1:0] soak_s,
                                 input logic [TEMP_W-1:0] cool_t);
    send_request(MODE_STOP, TEMP_W'($urandom()));
    send_request(MODE_TICK, '0);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SOAK_TEMP;
    cfg_data  <= soak_t;
    @(posedge clk);
    cfg_index <= CFG_REFLOW_TEMP;
    cfg_data  <= reflow_t;
    @(posedge clk);
    cfg_index <= CFG_SOAK_PERIOD;
    cfg_data  <= CFG_DATA_W'(soak_s);
    @(posedge clk);
    cfg_index <= CFG_COOL_TEMP;
    cfg_data  <= cool_t;
    @(posedge clk);
    cfg_we <= 1'b0;
    soak_temp_now   = soak_t;
    reflow_temp_now = reflow_t;
    soak_period_now = soak_s;
    cool_temp_now   = cool_t;
  endtask

  task automatic random_thresholds();
    logic [SOAK_W-1:0] secs;
    secs = ($urandom_range(99) < 90) ? SOAK_W'($urandom_range(6))
                                     : SOAK_W'($urandom_range(40, 7));
    load_thresholds(TEMP_W'($urandom()), TEMP_W'($urandom()), secs, TEMP_W'($urandom()));
  endtask

  // One full profile: start, ramp, soak, ramp, cool, with random temperatures
  task automatic run_profile();
    int unsigned soak_ticks;
    send_request(MODE_START, TEMP_W'($urandom()));
    if (soak_temp_now != 0)
      repeat ($urandom_range(3)) profile_tick(TEMP_W'($urandom_range(soak_temp_now - 1)));
    profile_tick(TEMP_W'($urandom_range(4095, soak_temp_now)));
    soak_ticks = (soak_period_now == 0) ? 1 : soak_period_now;
    repeat (soak_ticks) profile_tick(TEMP_W'($urandom()));
    if (reflow_temp_now != 0)
      repeat ($urandom_range(3)) profile_tick(TEMP_W'($urandom_range(reflow_temp_now - 1)));
    profile_tick(TEMP_W'($urandom_range(4095, reflow_temp_now)));
    if (cool_temp_now != 12'hFFF)
      repeat ($urandom_range(3)) profile_tick(TEMP_W'($urandom_range(4095, cool_temp_now + 1)));
    profile_tick(TEMP_W'($urandom_range(cool_temp_now)));
  endtask

  task automatic run_profiles(input int unsigned count);
    int unsigned stop_at;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) run_profile();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset thresholds: idle ticks, unused kind, stop from idle, cooling edge,
    // restart while soaking
    send_request(MODE_TICK, 12'd0);
    send_request(MODE_TICK, 12'hFFF);
    send_request(MODE_IGNORED, 12'hFFF);
    send_request(MODE_STOP, 12'd0);
    send_request(MODE_TICK, 12'd201);
    send_request(MODE_TICK, 12'd200);
    send_request(MODE_START, 12'd0);
    send_request(MODE_TICK, 12'd439);
    send_request(MODE_TICK, 12'd440);
    send_request(MODE_START, 12'hFFF);
    send_request(MODE_TICK, 12'hFFF);
    send_request(MODE_STOP, 12'd0);
    send_request(MODE_TICK, 12'd0);

    // Low extremes: zero soak time, zero soak threshold, reflow at the top
    load_thresholds(12'd0, 12'hFFF, 8'd0, 12'd0);
    send_request(MODE_START, 12'd0);
    send_request(MODE_TICK, 12'd0);
    send_request(MODE_TICK, 12'd2048);
    send_request(MODE_TICK, 12'hFFE);
    send_request(MODE_TICK, 12'hFFF);
    send_request(MODE_TICK, 12'd1);
    send_request(MODE_TICK, 12'd0);
    send_request(MODE_TICK, 12'hFFF);

    // High extremes: longest soak, reflow at zero, cooling ends at the top
    load_thresholds(12'hFFF, 12'd0, 8'hFF, 12'hFFF);
    send_request(MODE_START, 12'hFFF);
    send_request(MODE_TICK, 12'hFFE);
    send_request(MODE_TICK, 12'hFFF);
    repeat (255) send_request(MODE_TICK, TEMP_W'($urandom()));
    send_request(MODE_TICK, 12'd0);
    send_request(MODE_TICK, 12'hFFF);

    // Random profiles: sender rarely idle, receiver often stalled
    repeat (2) begin
      random_thresholds();
      run_profiles(100);
    end

    // Sender often idle, receiver rarely stalled
    send_idle_pct = 69;
    recv_idle_pct = 7;
    repeat (2) begin
      random_thresholds();
      run_profiles(100);
    end

    // Neither side idles; a long hold-off fills the block
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_thresholds();
    hold_trigger++;
    run_profiles(100);
    random_thresholds();
    run_profiles(100);

    // Let the last results come back
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS reflow_profile_sequencer_core");
    end else begin
      $display("FAIL reflow_profile_sequencer_core");
    end
    $finish;
  end

endmodule
